/* src/sbpd_pkg.sv */
// Shared types and constants of the start-byte packet deframer.
package sbpd_pkg;

	localparam int MSG_BYTES = 4;
	localparam int IDX_W = $clog2(MSG_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_BYTES - 1);

	localparam logic [7:0] DEF_AXIS = 8'd128;
	localparam logic [7:0] DEF_BUTTONS = 8'h00;
	localparam logic [7:0] DEF_CHECK = DEF_AXIS ^ DEF_AXIS ^ DEF_BUTTONS;
	localparam logic [7:0] MARKER_RST = 8'd64;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_COLLECT = 2'd1,
		MODE_READY = 2'd2
	} mode_t;

	typedef struct packed {
		op_t operation;
		logic [7:0] rx_byte;
		logic frame_error;
		logic parity_error;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] x_byte;
		logic [7:0] y_byte;
		logic [7:0] button_byte;
		logic [7:0] check_byte;
		logic [MSG_BYTES-1:0] byte_error_mask;
		logic was_defaulted;
	} msg_item_t;

endpackage

/* src/start_byte_packet_deframer_core.sv */
// Start-byte packet deframer: builds four-byte messages from received UART bytes.
//
// Input channel rx: one item per received byte (operation byte) or a release
// command (operation release) that frees a ready message and returns to idle.
// An idle block waits for the start marker byte with no parity or framing
// error, then collects x, y, buttons and check bytes. A framing error while
// collecting yields a default message flagged was_defaulted.
// Output channel msg: one item each time a message becomes ready.
// Config: cfg_we/cfg_wdata write the start marker (64 after reset); write it
// only while the block is idle.
// Pipeline: an item taken from rx is held in the input stage, and a result
// that it yields goes into the result register, which drives msg. One item
// per cycle is taken sustained unless msg is stalled with a result waiting;
// the input stage and the result register each hold one item. In that stall,
// the input stage holds and rx_stall rises as soon as that stage is occupied.
// Reset (arst_n low) returns the block to idle with an empty pipeline and the
// default start marker.
module start_byte_packet_deframer_core
	import sbpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_stall,
	input  rx_item_t rx_item,
	output logic msg_valid,
	input  logic msg_stall,
	output msg_item_t msg_item,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata
);

	rx_item_t item_s1;
	logic valid_s1;
	logic adv;
	logic fire;

	mode_t mode_q, mode_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [MSG_BYTES-1:0] err_mask_q, err_mask_d;
	logic [7:0] marker_q;
	logic [7:0] store_q [MSG_BYTES-1];
	logic store_we;

	logic emit;
	msg_item_t res_d;
	logic msg_valid_q;
	msg_item_t msg_item_q;

	logic is_byte;

	assign adv = !msg_valid_q || !msg_stall;
	assign fire = valid_s1 && adv;
	assign rx_stall = valid_s1 && !adv;
	assign is_byte = (item_s1.operation == OP_BYTE);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			item_s1 <= rx_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RST;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		idx_d = idx_q;
		err_mask_d = err_mask_q;
		if (fire) begin
			unique case (mode_q)
				MODE_READY: begin
					if (!is_byte) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_COLLECT: begin
					if (is_byte) begin
						if (item_s1.frame_error) begin
							mode_d = MODE_READY;
							idx_d = '0;
						end else begin
							err_mask_d[idx_q] = err_mask_q[idx_q] | item_s1.parity_error;
							idx_d = idx_q + 1'b1;
							if (idx_q == LAST_IDX) begin
								mode_d = MODE_READY;
							end
						end
					end
				end
				default: begin
					// idle, and the unused code behaves as idle
					if (is_byte) begin
						if (!item_s1.frame_error && !item_s1.parity_error &&
						    item_s1.rx_byte == marker_q) begin
							mode_d = MODE_COLLECT;
							idx_d = '0;
							err_mask_d = '0;
						end else begin
							mode_d = MODE_IDLE;
						end
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit = 1'b0;
		store_we = 1'b0;
		res_d.x_byte = store_q[0];
		res_d.y_byte = store_q[1];
		res_d.button_byte = store_q[2];
		res_d.check_byte = item_s1.rx_byte;
		res_d.byte_error_mask = err_mask_q;
		res_d.byte_error_mask[LAST_IDX] = item_s1.parity_error;
		res_d.was_defaulted = 1'b0;
		unique case (mode_q)
			MODE_COLLECT: begin
				if (fire && is_byte) begin
					if (item_s1.frame_error) begin
						emit = 1'b1;
						res_d.x_byte = DEF_AXIS;
						res_d.y_byte = DEF_AXIS;
						res_d.button_byte = DEF_BUTTONS;
						res_d.check_byte = DEF_CHECK;
						res_d.byte_error_mask = err_mask_q;
						res_d.was_defaulted = 1'b1;
					end else if (idx_q == LAST_IDX) begin
						emit = 1'b1;
					end else begin
						store_we = 1'b1;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			idx_q <= '0;
			err_mask_q <= '0;
		end else begin
			mode_q <= mode_d;
			idx_q <= idx_d;
			err_mask_q <= err_mask_d;
		end
	end

	// the last message byte goes straight to the result, so only the first ones are kept
	for (genvar i = 0; i < MSG_BYTES - 1; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (store_we && idx_q == IDX_W'(i)) begin
				store_q[i] <= item_s1.rx_byte;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_q <= 1'b0;
		end else if (adv) begin
			msg_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			msg_item_q <= res_d;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg_item = msg_item_q;

	a_emit_to_ready: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (mode_q == MODE_READY && msg_valid))
		else $error("result emitted without entering ready");

	a_idx_only_collect: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> (mode_q == MODE_COLLECT))
		else $error("byte index nonzero outside collecting");

	a_default_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && msg_item.was_defaulted) |->
		(msg_item.x_byte == DEF_AXIS && msg_item.y_byte == DEF_AXIS &&
		 msg_item.button_byte == DEF_BUTTONS && msg_item.check_byte == DEF_CHECK))
		else $error("defaulted message carries wrong bytes");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && msg_valid && msg_stall))
		else $error("input stalled without a blocked result");

	a_ready_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_READY) |-> !emit)
		else $error("result emitted while already ready");

endmodule
